// ----- design/gdd_pkg.sv -----
// shared types, codes and defaults for the gesture dwell debouncer
`default_nettype none

package gdd_pkg;

    localparam int CODE_BITS_DEF   = 4;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int FIELD_CODE_BITS = 4;
    localparam int CFG_BITS        = 8;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [1:0] FUNC_FRAME   = 2'd0;
    localparam logic [1:0] FUNC_DISARM  = 2'd1;
    localparam logic [1:0] FUNC_RESTORE = 2'd2;
    localparam logic [1:0] FUNC_SOFT_RST = 2'd3;

    localparam logic [1:0] REG_ENTER   = 2'd0;
    localparam logic [1:0] REG_SWITCH  = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;

    localparam logic [CFG_BITS-1:0] ENTER_RST   = 8'd3;
    localparam logic [CFG_BITS-1:0] SWITCH_RST  = 8'd3;
    localparam logic [CFG_BITS-1:0] RELEASE_RST = 8'd5;

    typedef struct packed {
        logic [1:0]                 func;
        logic                       hand_present;
        logic [FIELD_CODE_BITS-1:0] stable_code;
        logic                       restore_armed;
        logic [FIELD_CODE_BITS-1:0] restore_blocked;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_CODE_BITS-1:0] held_gesture;
        logic                       entered;
        logic                       exited;
        logic [FIELD_CODE_BITS-1:0] exited_code;
        logic                       continuous_active;
        logic                       armed_flag;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_BITS-1:0] enter_frames;
        logic [CFG_BITS-1:0] switch_frames;
        logic [CFG_BITS-1:0] release_frames;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/gdd_cfg.sv -----
// apb threshold registers
`default_nettype none

module gdd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gdd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [gdd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [gdd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                     pready,
    output gdd_pkg::t_cfg                            o_cfg
);
    import gdd_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_frames   <= ENTER_RST;
            r_cfg.switch_frames  <= SWITCH_RST;
            r_cfg.release_frames <= RELEASE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENTER:   r_cfg.enter_frames   <= pwdata[CFG_BITS-1:0];
                REG_SWITCH:  r_cfg.switch_frames  <= pwdata[CFG_BITS-1:0];
                REG_RELEASE: r_cfg.release_frames <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENTER:   prdata = APB_DATA_BITS'(r_cfg.enter_frames);
            REG_SWITCH:  prdata = APB_DATA_BITS'(r_cfg.switch_frames);
            REG_RELEASE: prdata = APB_DATA_BITS'(r_cfg.release_frames);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/gdd_in_stage.sv -----
// input register with stall toward the source
`default_nettype none

module gdd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gdd_pkg::t_in_beat i_in_data,
    input  wire logic              i_advance,
    output logic                   o_beat_valid,
    output gdd_pkg::t_in_beat      o_beat
);
    import gdd_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;
    logic     accept;

    assign o_in_stall   = r_valid && !i_advance;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/gdd_core.sv -----
// dwell, switch and release state with the result register
`default_nettype none

module gdd_core #(
    parameter int CODE_BITS  = gdd_pkg::CODE_BITS_DEF,
    parameter int COUNT_BITS = gdd_pkg::COUNT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gdd_pkg::t_cfg     i_cfg,
    input  wire logic              i_beat_valid,
    input  wire gdd_pkg::t_in_beat i_beat,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output gdd_pkg::t_out_beat     o_out_data
);
    import gdd_pkg::*;

    localparam int XW = (CODE_BITS > FIELD_CODE_BITS) ? CODE_BITS : FIELD_CODE_BITS;
    localparam int CW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    typedef logic [CODE_BITS-1:0]  t_code;
    typedef logic [COUNT_BITS-1:0] t_count;

    function automatic t_code to_code(input logic [FIELD_CODE_BITS-1:0] f);
        logic [XW-1:0] w;
        w = XW'(f);
        return w[CODE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_CODE_BITS-1:0] to_field(input t_code c);
        logic [XW-1:0] w;
        w = XW'(c);
        return w[FIELD_CODE_BITS-1:0];
    endfunction

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

    function automatic logic reaches(input t_count v, input logic [CFG_BITS-1:0] thr);
        return CW'(v) >= CW'(thr);
    endfunction

    logic      r_armed;
    t_code     r_accepted;
    t_code     r_blocked;
    t_code     r_cand;
    t_count    r_cand_cnt;
    t_count    r_missing;
    logic      r_out_valid;
    t_out_beat r_out;

    logic      n_armed;
    t_code     n_accepted;
    t_code     n_blocked;
    t_code     n_cand;
    t_count    n_cand_cnt;
    t_count    n_missing;
    t_out_beat n_out;

    logic      fire;
    t_code     code;

    assign o_advance   = !r_out_valid || !i_out_stall;
    assign fire        = i_beat_valid && o_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign code        = to_code(i_beat.stable_code);

    always_comb begin
        t_code  held;
        t_code  ex_code;
        logic   ent;
        logic   ex;
        logic   cont;
        t_code  cand_c;
        t_count cand_n;
        logic   [CFG_BITS-1:0] need;

        n_armed    = r_armed;
        n_accepted = r_accepted;
        n_blocked  = r_blocked;
        n_cand     = r_cand;
        n_cand_cnt = r_cand_cnt;
        n_missing  = r_missing;
        held       = '0;
        ex_code    = '0;
        ent        = 1'b0;
        ex         = 1'b0;
        cont       = 1'b0;
        cand_c     = r_cand;
        cand_n     = r_cand_cnt;
        need       = i_cfg.enter_frames;

        case (i_beat.func)
            FUNC_DISARM: begin
                if (r_accepted == '0) begin
                    n_armed   = 1'b1;
                    n_blocked = '0;
                end else begin
                    n_armed   = 1'b0;
                    n_blocked = r_accepted;
                end
                n_accepted = '0;
                n_cand     = '0;
                n_cand_cnt = '0;
                n_missing  = '0;
            end
            FUNC_RESTORE: begin
                n_armed    = i_beat.restore_armed;
                n_accepted = '0;
                n_blocked  = i_beat.restore_armed ? t_code'(0)
                                                  : to_code(i_beat.restore_blocked);
                n_cand     = '0;
                n_cand_cnt = '0;
                n_missing  = '0;
            end
            FUNC_SOFT_RST: begin
                n_armed    = 1'b1;
                n_accepted = '0;
                n_blocked  = '0;
                n_cand     = '0;
                n_cand_cnt = '0;
                n_missing  = '0;
            end
            default: begin
                if (!i_beat.hand_present || code == '0) begin
                    n_missing  = sat_inc(r_missing);
                    n_cand     = '0;
                    n_cand_cnt = '0;
                    if (reaches(n_missing, i_cfg.release_frames)) begin
                        if (r_accepted != '0) begin
                            ex      = 1'b1;
                            ex_code = r_accepted;
                        end
                        n_accepted = '0;
                        n_armed    = 1'b1;
                        n_blocked  = '0;
                    end
                end else begin
                    n_missing = '0;
                    if (!r_armed && code == r_blocked) begin
                        held = r_accepted;
                    end else begin
                        if (!r_armed) begin
                            n_armed   = 1'b1;
                            n_blocked = '0;
                            cand_c    = '0;
                            cand_n    = '0;
                        end
                        if (code == r_accepted) begin
                            n_cand     = '0;
                            n_cand_cnt = '0;
                            held       = r_accepted;
                            cont       = 1'b1;
                        end else begin
                            if (cand_c != code) begin
                                cand_n = t_count'(1);
                            end else begin
                                cand_n = sat_inc(cand_n);
                            end
                            need = (r_accepted == '0) ? i_cfg.enter_frames
                                                      : i_cfg.switch_frames;
                            if (!reaches(cand_n, need)) begin
                                n_cand     = code;
                                n_cand_cnt = cand_n;
                                held       = r_accepted;
                                cont       = (r_accepted != '0);
                            end else begin
                                if (r_accepted != '0) begin
                                    ex      = 1'b1;
                                    ex_code = r_accepted;
                                end
                                n_accepted = code;
                                n_cand     = '0;
                                n_cand_cnt = '0;
                                held       = code;
                                ent        = 1'b1;
                                cont       = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase

        n_out.held_gesture      = to_field(held);
        n_out.entered           = ent;
        n_out.exited            = ex;
        n_out.exited_code       = to_field(ex_code);
        n_out.continuous_active = cont;
        n_out.armed_flag        = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b1;
            r_accepted  <= '0;
            r_blocked   <= '0;
            r_cand      <= '0;
            r_cand_cnt  <= '0;
            r_missing   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_armed    <= n_armed;
                r_accepted <= n_accepted;
                r_blocked  <= n_blocked;
                r_cand     <= n_cand;
                r_cand_cnt <= n_cand_cnt;
                r_missing  <= n_missing;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_accepted_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accepted != '0) |-> r_armed)
        else $error("accepted gesture while disarmed");

    a_blocked_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blocked != '0) |-> !r_armed)
        else $error("blocked gesture while armed");

    a_cand_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cand == '0) == (r_cand_cnt == '0)))
        else $error("candidate code and count disagree");

    a_enter_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.entered) |->
            (r_out.continuous_active && r_out.held_gesture != '0 && r_out.armed_flag))
        else $error("entry beat without held gesture");

    a_exit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.exited) |-> (r_out.exited_code != '0))
        else $error("exit beat without code");
`endif

endmodule

`default_nettype wire

// ----- design/gesture_dwell_debouncer.sv -----
// a beat moves from the input register to the result register
// throughput: one beat per cycle when unstalled, set by the single-pass state update
// the input register and result register each hold one beat across stalls
// reset: synchronous active low; armed, no gesture held, no candidate,
// counters zero, thresholds enter 3, switch 3, release 5
`default_nettype none

module gesture_dwell_debouncer #(
    parameter int CODE_BITS  = gdd_pkg::CODE_BITS_DEF,
    parameter int COUNT_BITS = gdd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire gdd_pkg::t_in_beat                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output gdd_pkg::t_out_beat                     o_out_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gdd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [gdd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [gdd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready
);
    import gdd_pkg::*;

    t_cfg     cfg;
    logic     advance;
    logic     beat_valid;
    t_in_beat beat;

    gdd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gdd_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_advance    (advance),
        .o_beat_valid (beat_valid),
        .o_beat       (beat)
    );

    gdd_core #(
        .CODE_BITS  (CODE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
